[rtl/msdd_pkg.sv]
// Package: state encoding, item codes and modulator constants for the sigma-delta dimmer.
`timescale 1ns / 1ps

package msdd_pkg;

    localparam int unsigned PIN_W   = 12;
    localparam int unsigned LEVEL_W = 16;
    localparam int unsigned ACC_W   = 21;
    localparam int unsigned SUM_W   = ACC_W + 1;
    localparam int unsigned ID_W    = 16;

    localparam logic FUNC_SET  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic signed [SUM_W-1:0] FULL_SCALE = 22'sh00fffe;
    localparam logic signed [SUM_W-1:0] SIGMA_MAX  = 22'sd655360;
    localparam logic signed [SUM_W-1:0] SIGMA_MIN  = -22'sd655360;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } msdd_state_t;

endpackage

[rtl/multichannel_sigma_delta_dimmer_unit.sv]
// Multi-channel first-order sigma-delta dimmer with one shared squarer and accumulate stage.
`timescale 1ns / 1ps

// Set-level transaction: taken with no result; the unit stays ready for the next one.
// Tick transaction: one channel enters the squarer per cycle, the accumulator follows in
// the cycle after; the result is loaded from the done state once the output register is
// free, and the unit then returns to idle and takes the next transaction.
// The single squarer/accumulator pair works on one tick at a time until its result is loaded.
// Reset (aresetn low, synchronous) clears levels, accumulators, base_channel and output valid.
module multichannel_sigma_delta_dimmer_unit #(
    parameter int CHANNELS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] global_id, [31:16] value
    input  logic [0:0]  s_tuser,   // [0] func
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] pin_states, [15:12] zero
    // base_channel register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import msdd_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(CHANNELS + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CHANNELS);
    localparam logic [ID_W-1:0]  CHAN_ID  = ID_W'(CHANNELS);

    msdd_state_t state_reg, state_next;

    logic [ID_W-1:0]            base_reg;
    logic [LEVEL_W-1:0]         level_reg [CHANNELS];
    logic signed [ACC_W-1:0]    acc_reg   [CHANNELS];
    logic [CHANNELS-1:0]        pins_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [2*LEVEL_W-1:0]       prod_reg;
    logic [IDX_W-1:0]           prod_idx_reg;
    logic                       prod_vld_reg;
    logic                       m_tvalid_reg;
    logic [15:0]                m_tdata_reg;

    logic                       s_accept;
    logic                       set_hit;
    logic [ID_W-1:0]            local_id;
    logic                       walk_active;
    logic                       out_load;
    logic                       out_free;
    logic signed [SUM_W-1:0]    acc_ext;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SUM_W-1:0]    sum_clamped;
    logic [PIN_W-1:0]           pin_field;

    assign s_accept = s_tvalid & s_tready;
    assign local_id = s_tdata[ID_W-1:0] - base_reg;
    assign set_hit  = s_accept && (s_tuser[0] == FUNC_SET) && (local_id < CHAN_ID);
    assign out_free = ~m_tvalid_reg | m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_tuser[0] == FUNC_TICK)) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (cnt_reg == LAST_CNT) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        s_tready    = 1'b0;
        walk_active = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready    = 1'b1;
            ST_RUN:  walk_active = (cnt_reg < LAST_CNT);
            ST_DONE: out_load    = out_free;
            default: ;
        endcase
    end

    // Shared accumulate and clamp stage
    always_comb begin
        acc_ext = SUM_W'(acc_reg[prod_idx_reg]);
        sum = acc_ext + $signed({{(SUM_W-LEVEL_W){1'b0}}, prod_reg[2*LEVEL_W-1:LEVEL_W]});
        if (!acc_ext[SUM_W-1]) begin
            sum = sum - FULL_SCALE;
        end
        priority if (sum > SIGMA_MAX) begin
            sum_clamped = SIGMA_MAX;
        end else if (sum < SIGMA_MIN) begin
            sum_clamped = SIGMA_MIN;
        end else begin
            sum_clamped = sum;
        end
    end

    // Pins beyond the field width are modulated but not reported
    for (genvar i = 0; i < PIN_W; i++) begin : g_pin
        if (i < CHANNELS) begin : g_used
            assign pin_field[i] = pins_reg[i];
        end else begin : g_unused
            assign pin_field[i] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            base_reg     <= '0;
            cnt_reg      <= '0;
            prod_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                level_reg[i] <= '0;
                acc_reg[i]   <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                base_reg <= cfg_data;
            end
            if (set_hit) begin
                level_reg[local_id[IDX_W-1:0]] <= s_tdata[31:16];
            end
            if (state_reg == ST_RUN) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else begin
                cnt_reg <= '0;
            end
            prod_vld_reg <= walk_active;
            if (prod_vld_reg) begin
                acc_reg[prod_idx_reg] <= sum_clamped[ACC_W-1:0];
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (walk_active) begin
            prod_reg     <= level_reg[cnt_reg[IDX_W-1:0]] * level_reg[cnt_reg[IDX_W-1:0]];
            prod_idx_reg <= cnt_reg[IDX_W-1:0];
        end
        if (prod_vld_reg) begin
            pins_reg[prod_idx_reg] <= ~sum_clamped[SUM_W-1];
        end
        if (out_load) begin
            m_tdata_reg <= {{(16-PIN_W){1'b0}}, pin_field};
        end
    end

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

`ifndef NO_ASSERTIONS
    a_prod_only_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        prod_vld_reg |-> (state_reg == ST_RUN))
        else $error("accumulate stage active outside the channel walk");

    a_walk_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) && (cnt_reg == LAST_CNT) |=> (state_reg == ST_DONE))
        else $error("channel walk did not finish after the last channel");

    a_acc_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        prod_vld_reg |=> ((SUM_W'(acc_reg[$past(prod_idx_reg)]) <= SIGMA_MAX)
                       && (SUM_W'(acc_reg[$past(prod_idx_reg)]) >= SIGMA_MIN)))
        else $error("accumulator left the clamp range");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result raised outside the done state");
`endif

endmodule
